FILE: sv/ism_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants for the 9x9 smoothing window core.
// ----------------------------------------------------------------------------
package ism_pkg;

	localparam int PIX_W   = 8;
	localparam int KSIZE   = 9;
	localparam int LROWS   = 8;
	localparam int ROW_W   = 17;
	localparam int ACC_W   = 19;
	localparam int QIN_W   = ACC_W - 5;
	localparam int RECIP_W = 10;
	localparam int PROD_W  = QIN_W + RECIP_W;
	localparam int RECIP_SHIFT = 15;
	localparam logic [RECIP_W-1:0] RECIP = 10'd993;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [7:0] KERN [KSIZE][KSIZE] = '{
		'{8'd0, 8'd1,  8'd2,  8'd4,  8'd8,   8'd4,  8'd2,  8'd1,  8'd0},
		'{8'd1, 8'd2,  8'd4,  8'd8,  8'd16,  8'd8,  8'd4,  8'd2,  8'd1},
		'{8'd2, 8'd4,  8'd8,  8'd16, 8'd32,  8'd16, 8'd8,  8'd4,  8'd2},
		'{8'd4, 8'd8,  8'd16, 8'd32, 8'd64,  8'd32, 8'd16, 8'd8,  8'd4},
		'{8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'd64, 8'd32, 8'd16, 8'd8},
		'{8'd4, 8'd8,  8'd16, 8'd32, 8'd64,  8'd32, 8'd16, 8'd8,  8'd4},
		'{8'd2, 8'd4,  8'd8,  8'd16, 8'd32,  8'd16, 8'd8,  8'd4,  8'd2},
		'{8'd1, 8'd2,  8'd4,  8'd8,  8'd16,  8'd8,  8'd4,  8'd2,  8'd1},
		'{8'd0, 8'd1,  8'd2,  8'd4,  8'd8,   8'd4,  8'd2,  8'd1,  8'd0}
	};

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [KSIZE-1:0] column_t;

	typedef struct packed {
		logic adv;
		logic shift;
	} win_ctl_t;

	typedef struct packed {
		logic        has_b;
		logic        has_f;
		logic [11:0] b_row;
		logic [9:0]  b_col;
		pix_t        pix;
		logic [11:0] f_row;
		logic [9:0]  f_col;
	} item_t;

endpackage
`default_nettype wire

FILE: sv/image_smooth_9x9_window_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_smooth_9x9_window_core
// Raster-stream 9x9 smoothing filter with border pass-through.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_valid/in_stall channel, one request
// per clock at full rate while in_stall is low. The core keeps its own row
// and column count. Each pixel yields zero, one or two results on the
// out_valid/out_stall channel: a border pass-through first, then a filtered
// pixel for the window centered four rows and four columns back. last_of_run
// marks the final result of a pixel. Throughput is one pixel per cycle when
// not held; each pixel taken reads all eight line-store banks and writes one.
// A pixel with two results holds the pipeline while its border result is
// sent. When the receiver stalls, the output register holds and the pipeline
// freezes, so in_stall rises. Reset clears the counters, the window and the
// pipeline, and loads width 800 and height 600; the line store is not
// cleared. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must do so only while idle, as the core does not enforce it.
// ----------------------------------------------------------------------------
module image_smooth_9x9_window_core import ism_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  pixel_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [11:0] out_row,
	output logic      [9:0]  out_col,
	output logic      [7:0]  out_value,
	output logic             is_border,
	output logic             last_of_run
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;

	logic [10:0]   width_q;
	logic [11:0]   height_q;
	logic [AW-1:0] col_q;
	logic [11:0]   row_q;

	logic [13:0]   wr;
	logic [CW-1:0] w;
	logic [11:0]   h;
	logic [AW-1:0] cc;
	logic [CW-1:0] cc_x;
	logic [CW-1:0] cn;
	logic [11:0]   rr;
	logic          accept;
	logic          adv;
	logic          hold;
	logic          done;
	item_t         it_d;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	item_t         it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [2:0]    r3_s1;
	logic [PROD_W-1:0] prod_s5;
	logic          sent_q;
	logic          cur_b;

	pix_t [LROWS-1:0] rd;
	column_t          col_in;
	win_ctl_t         wctl;
	logic [ACC_W-1:0] acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd800;
			height_q <= 12'd600;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		wr = {3'b0, width_q};
		if (wr < 14'd9) begin
			wr = 14'd9;
		end
		if (wr > 14'(MAX_WIDTH)) begin
			wr = 14'(MAX_WIDTH);
		end
		w = CW'(wr);
		h = (height_q < 12'd9) ? 12'd9 : height_q;
		cc = ({1'b0, col_q} >= w) ? '0 : col_q;
		rr = (row_q >= h) ? '0 : row_q;
		cc_x = {1'b0, cc};
		cn = cc_x + CW'(1);
	end

	always_comb begin
		it_d.has_b = (rr < 12'd4) || (rr >= h - 12'd4) || (cc_x < CW'(4))
			|| (cc_x >= w - CW'(4));
		it_d.has_f = (rr >= 12'd8) && (cc_x >= CW'(8));
		it_d.b_row = rr;
		it_d.b_col = 10'(cc_x);
		it_d.pix   = pixel_value;
		it_d.f_row = rr - 12'd4;
		it_d.f_col = 10'(cc_x - CW'(4));
	end

	assign cur_b       = it_s5.has_b && !sent_q;
	assign out_valid   = v_s5 && (cur_b || it_s5.has_f);
	assign out_row     = cur_b ? it_s5.b_row : it_s5.f_row;
	assign out_col     = cur_b ? it_s5.b_col : it_s5.f_col;
	assign out_value   = cur_b ? it_s5.pix : prod_s5[RECIP_SHIFT +: PIX_W];
	assign is_border   = cur_b;
	assign last_of_run = !(cur_b && it_s5.has_f);

	assign done     = !out_valid || (!out_stall && last_of_run);
	assign hold     = v_s5 && !done;
	assign adv      = !hold;
	assign in_stall = hold;
	assign accept   = in_valid && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cn >= w) begin
				col_q <= '0;
				row_q <= (rr + 12'd1 >= h) ? 12'd0 : rr + 12'd1;
			end else begin
				col_q <= AW'(cn);
				row_q <= rr;
			end
		end
	end

	for (genvar b = 0; b < LROWS; b++) begin : g_bank
		ism_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_bank (
			.clk  (clk),
			.we   (accept && (rr[2:0] == 3'(b))),
			.waddr(cc),
			.wdata(pixel_value),
			.re   (accept),
			.raddr(cc),
			.rdata(rd[b])
		);
	end

	always_comb begin
		for (int y = 0; y < LROWS; y++) begin
			col_in[y] = rd[3'(r3_s1 + 3'(y))];
		end
		col_in[KSIZE-1] = it_s1.pix;
	end

	assign wctl.adv   = adv;
	assign wctl.shift = adv && v_s1;

	ism_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (wctl),
		.col_in(col_in),
		.acc   (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			sent_q <= 1'b0;
		end else if (adv) begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			sent_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			sent_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= it_d;
			r3_s1   <= rr[2:0];
			it_s2   <= it_s1;
			it_s3   <= it_s2;
			it_s4   <= it_s3;
			it_s5   <= it_s4;
			prod_s5 <= PROD_W'(acc[ACC_W-1:5]) * PROD_W'(RECIP);
		end
	end

endmodule
`default_nettype wire

FILE: sv/ism_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ism_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ism_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/ism_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ism_window
// 9x9 window shift register with a two-stage weighted sum.
// ----------------------------------------------------------------------------
module ism_window import ism_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire win_ctl_t         ctl,
	input  wire column_t          col_in,
	output logic      [ACC_W-1:0] acc
);

	pix_t [KSIZE-1:0][KSIZE-1:0] win_q;
	pix_t [KSIZE-1:0][KSIZE-1:0] win_d;
	logic [KSIZE-1:0][ROW_W-1:0] rs_d;
	logic [KSIZE-1:0][ROW_W-1:0] rs_s3;
	logic [ACC_W-1:0]            tot_d;
	logic [ACC_W-1:0]            acc_s4;

	always_comb begin
		for (int y = 0; y < KSIZE; y++) begin
			for (int x = 0; x < KSIZE - 1; x++) begin
				win_d[y][x] = win_q[y][x+1];
			end
			win_d[y][KSIZE-1] = col_in[y];
		end
	end

	always_comb begin
		for (int y = 0; y < KSIZE; y++) begin
			rs_d[y] = '0;
			for (int x = 0; x < KSIZE; x++) begin
				rs_d[y] = rs_d[y] + ROW_W'(win_q[y][x]) * ROW_W'(KERN[y][x]);
			end
		end
	end

	always_comb begin
		tot_d = '0;
		for (int y = 0; y < KSIZE; y++) begin
			tot_d = tot_d + ACC_W'(rs_s3[y]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= win_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rs_s3  <= rs_d;
			acc_s4 <= tot_d;
		end
	end

	assign acc = acc_s4;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 9x9 smoothing window core.
// ----------------------------------------------------------------------------
// A clocked driver sends pixels and configuration writes from a queue that
// the stimulus process fills. A clocked monitor stalls the result channel at
// random and compares each result with the oldest entry of a queue that an
// internal predictor of the window, the line store and the counters fills.
// A first full frame, wider than any column later phases reach, fills the
// line store. Random phases of small frames follow, with mid-frame size
// changes.
// ----------------------------------------------------------------------------
module tb;
	import ism_pkg::*;

	typedef enum logic [1:0] {PIXEL, CFG_WRITE, SYNC, HOLD} op_t;

	typedef struct {
		op_t         op;
		logic [0:0]  idx;
		logic [11:0] data;
		int          gap;
	} request_t;

	typedef struct {
		logic [11:0] row;
		logic [9:0]  col;
		logic [7:0]  value;
		logic        border;
		logic        last;
	} pixel_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  pixel_value;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic [7:0]  out_value;
	logic        is_border;
	logic        last_of_run;

	request_t      requests[$];
	pixel_result_t expected_pixels[$];
	int            errors = 0;
	bit            taken = 0;
	int            settle = 0;
	int            long_hold = 0;
	int            rx_wait = 0;
	int            rx_max = 7;

	logic [10:0] width_reg;
	logic [11:0] height_reg;
	logic [7:0]  line_mem [8][1024];
	logic [7:0]  win [9][9];
	int          cur_row;
	int          cur_col;

	image_smooth_9x9_window_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.pixel_value(pixel_value), .out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_col(out_col), .out_value(out_value),
		.is_border(is_border), .last_of_run(last_of_run)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int weight(int y, int x);
		int d;
		d = (y > 4 ? y - 4 : 4 - y) + (x > 4 ? x - 4 : 4 - x);
		return d <= 7 ? (1 << (7 - d)) : 0;
	endfunction

	function automatic void smooth_step(logic [7:0] pix);
		int w;
		int h;
		int r;
		int c;
		int acc;
		bit any;
		pixel_result_t res;
		w = width_reg < 9 ? 9 : (width_reg > 1024 ? 1024 : width_reg);
		h = height_reg < 9 ? 9 : height_reg;
		any = 0;
		if (cur_col >= w) cur_col = 0;
		if (cur_row >= h) cur_row = 0;
		r = cur_row;
		c = cur_col;
		for (int y = 0; y < 9; y++)
			for (int x = 0; x < 8; x++)
				win[y][x] = win[y][x + 1];
		for (int y = 0; y < 8; y++)
			win[y][8] = line_mem[(r + y) & 7][c];
		win[8][8] = pix;
		line_mem[r & 7][c] = pix;
		if (r < 4 || r >= h - 4 || c < 4 || c >= w - 4) begin
			res = '{r[11:0], c[9:0], pix, 1'b1, 1'b0};
			expected_pixels.push_back(res);
			any = 1;
		end
		if (r >= 8 && c >= 8) begin
			acc = 0;
			for (int y = 0; y < 9; y++)
				for (int x = 0; x < 9; x++)
					acc += win[y][x] * weight(y, x);
			acc = acc / 1056;
			res = '{12'(r - 4), 10'(c - 4), acc[7:0], 1'b0, 1'b0};
			expected_pixels.push_back(res);
			any = 1;
		end
		if (any) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
		cur_col = c + 1;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row = r + 1;
			if (cur_row >= h) cur_row = 0;
		end
	endfunction

	always @(posedge clk) begin
		pixel_result_t e;
		if (cfg_we) begin
			if (cfg_index == REG_WIDTH) width_reg = cfg_data[10:0];
			else height_reg = cfg_data;
		end
		if (in_valid && !in_stall) begin
			smooth_step(pixel_value);
			taken = 1;
		end
		if (out_valid && !out_stall) begin
			rx_wait = $urandom_range(0, rx_max);
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result row %0d col %0d value %0d",
						out_row, out_col, out_value);
			end else begin
				e = expected_pixels.pop_front();
				if (e.row !== out_row || e.col !== out_col || e.value !== out_value
						|| e.border !== is_border || e.last !== last_of_run) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp r%0d c%0d v%0d b%0d l%0d got r%0d c%0d v%0d b%0d l%0d",
							e.row, e.col, e.value, e.border, e.last,
							out_row, out_col, out_value, is_border, last_of_run);
				end
			end
		end
	end

	always @(negedge clk) begin
		logic        nv;
		logic        nwe;
		logic [7:0]  npix;
		logic [0:0]  nidx;
		logic [11:0] ndata;
		nv = in_valid;
		npix = pixel_value;
		nwe = 1'b0;
		nidx = cfg_index;
		ndata = cfg_data;
		if (arst_n && (!in_valid || taken)) begin
			nv = 1'b0;
			if (requests.size() != 0) begin
				case (requests[0].op)
					PIXEL: begin
						if (requests[0].gap > 0) begin
							requests[0].gap--;
						end else begin
							nv = 1'b1;
							npix = requests[0].data[7:0];
							void'(requests.pop_front());
						end
					end
					HOLD: begin
						long_hold = requests[0].gap;
						void'(requests.pop_front());
					end
					default: begin
						if (expected_pixels.size() != 0) begin
							settle = 0;
						end else if (settle < 12) begin
							settle++;
						end else begin
							settle = 0;
							if (requests[0].op == CFG_WRITE) begin
								nwe = 1'b1;
								nidx = requests[0].idx;
								ndata = requests[0].data;
							end
							void'(requests.pop_front());
						end
					end
				endcase
			end
		end
		taken = 0;
		in_valid <= nv;
		pixel_value <= npix;
		cfg_we <= nwe;
		cfg_index <= nidx;
		cfg_data <= ndata;
		if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic add_pixel(logic [7:0] v, int max_gap);
		request_t q;
		q = '{PIXEL, 1'b0, {4'd0, v}, $urandom_range(0, max_gap)};
		requests.push_back(q);
	endtask

	task automatic add_cfg(logic [0:0] idx, logic [11:0] v);
		request_t q;
		q = '{CFG_WRITE, idx, v, 0};
		requests.push_back(q);
	endtask

	task automatic add_control(op_t op, int n);
		request_t q;
		q = '{op, 1'b0, 12'd0, n};
		requests.push_back(q);
	endtask

	initial begin
		int w;
		int h;
		int n;
		int gmax;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_value = '0;
		out_stall = 1'b0;
		width_reg = 11'd800;
		height_reg = 12'd600;
		cur_row = 0;
		cur_col = 0;
		for (int y = 0; y < 9; y++)
			for (int x = 0; x < 9; x++)
				win[y][x] = '0;
		for (int y = 0; y < 8; y++)
			for (int x = 0; x < 1024; x++)
				line_mem[y][x] = '0;

		add_cfg(REG_WIDTH, 12'd96);
		add_cfg(REG_HEIGHT, 12'd3);
		for (int i = 0; i < 96 * 9; i++)
			add_pixel(i % 7 == 0 ? 8'hFF : (i % 5 == 0 ? 8'h00 : 8'($urandom)),
				i < 400 ? 0 : 2);

		add_cfg(REG_WIDTH, 12'd0);
		add_cfg(REG_HEIGHT, 12'd9);
		for (int i = 0; i < 25; i++)
			add_pixel(i[0] ? 8'hFF : 8'h00, 1);

		for (int p = 0; p < 12; p++) begin
			case (p % 6)
				0: begin w = 9; h = 4095; end
				1: begin w = 1024; h = 9; end
				2: begin w = 1100; h = 10; end
				default: begin
					w = $urandom_range(9, 40);
					h = $urandom_range(5, 20);
				end
			endcase
			add_control(SYNC, 0);
			add_cfg(REG_WIDTH, 12'(w));
			add_cfg(REG_HEIGHT, 12'(h));
			n = (w > 100) ? 40 : $urandom_range(60, 120);
			gmax = (p % 3 == 1) ? 0 : 7;
			for (int i = 0; i < n; i++) begin
				if (p == 4 && i == 20) add_control(HOLD, 300);
				if (p == 7 && i == 20) add_control(SYNC, 0);
				add_pixel(8'($urandom), gmax);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (requests.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_pixels.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ism_pkg.sv
sv/ism_ram.sv
sv/ism_window.sv
sv/image_smooth_9x9_window_core.sv
verif/tb.sv
